>>> rtl/ilie_pkg.sv
// ----------------------------------------------------------------------------
// ilie_pkg
// Shared types and codes for the indexed list insert/erase core.
// ----------------------------------------------------------------------------
`default_nettype none

package ilie_pkg;

    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 5;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_READ   = 3'd0;
    localparam action_t ACT_INSERT = 3'd1;
    localparam action_t ACT_ERASE  = 3'd2;
    localparam action_t ACT_PUSH   = 3'd3;
    localparam action_t ACT_POP    = 3'd4;
    localparam action_t ACT_CLEAR  = 3'd5;
    localparam action_t ACT_RESIZE = 3'd6;
    localparam action_t ACT_ASSIGN = 3'd7;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_INDEX = 2'd1;
    localparam status_t ST_FULL  = 2'd2;
    localparam status_t ST_EMPTY = 2'd3;

endpackage

`default_nettype wire

>>> rtl/ilie_ram.sv
// ----------------------------------------------------------------------------
// ilie_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ilie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/indexed_list_insert_erase_core.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_erase_core
// Bounded ordered list of signed 32-bit entries with read, insert, erase,
// push, pop, clear, resize and assign, one result per transaction.
// ----------------------------------------------------------------------------
// The list lives in one RAM with a registered read port, and a small sequencer
// moves one entry at a time, read in S_STEP and written in S_MOVE. A transaction
// is accepted in S_IDLE and checked in S_DECODE; then a read captures the RAM
// output in S_RDCAP, an insert or erase shifts entries through S_STEP and
// S_MOVE, a resize or assign writes its entries in S_STEP, and push, pop, clear
// and every rejected transaction go straight to S_DONE. S_DONE moves the result
// into the output register, where it sits until taken. The input is ready again
// once the result has moved there; a following result waits in the sequencer
// until the output register is free. Entry moves are bounded by the single RAM port pair.
`default_nettype none

module indexed_list_insert_erase_core
    import ilie_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action[2:0], index[7:3], value[39:8], count[44:40], zero pad[47:45]
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_value[31:0], length_now[36:32], is_empty[37], status[39:38]
    output logic      [39:0] m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = ((LW > INDEX_W) ? LW : INDEX_W) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_STEP   = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_RDCAP  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    action_t            act_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [VALUE_W-1:0] rd_reg, rd_next;
    status_t            st_reg, st_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [39:0]        m_tdata_reg;

    logic [CW-1:0]      len_ext, idx_ext, cnt_ext;
    logic [CW-1:0]      ptr_dec, ptr_inc;
    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [VALUE_W-1:0] wdata, rdata;
    logic               out_load;

    assign len_ext = CW'(len_reg);
    assign idx_ext = CW'(idx_reg);
    assign cnt_ext = CW'(cnt_reg);
    assign ptr_dec = ptr_reg - 1'b1;
    assign ptr_inc = ptr_reg + 1'b1;

    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        case (act_reg)
            ACT_INSERT: raddr = ptr_dec[AW-1:0];
            ACT_ERASE:  raddr = ptr_inc[AW-1:0];
            default:    raddr = idx_ext[AW-1:0];
        endcase
    end

    ilie_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        rd_next    = rd_reg;
        st_next    = st_reg;
        we         = 1'b0;
        waddr      = ptr_reg[AW-1:0];
        wdata      = val_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                rd_next    = '0;
                st_next    = ST_OK;
                state_next = S_DONE;
                case (act_reg)
                    ACT_READ: begin
                        if (idx_ext >= len_ext) begin
                            st_next = ST_INDEX;
                        end else begin
                            state_next = S_RDCAP;
                        end
                    end
                    ACT_INSERT: begin
                        if (idx_ext > len_ext) begin
                            st_next = ST_INDEX;
                        end else if (len_ext >= DEPTH_C) begin
                            st_next = ST_FULL;
                        end else begin
                            ptr_next   = len_ext;
                            state_next = S_STEP;
                        end
                    end
                    ACT_ERASE: begin
                        if (idx_ext >= len_ext) begin
                            st_next = ST_INDEX;
                        end else begin
                            ptr_next   = idx_ext;
                            state_next = S_STEP;
                        end
                    end
                    ACT_PUSH: begin
                        if (len_ext >= DEPTH_C) begin
                            st_next = ST_FULL;
                        end else begin
                            we       = 1'b1;
                            waddr    = len_ext[AW-1:0];
                            len_next = len_reg + 1'b1;
                        end
                    end
                    ACT_POP: begin
                        if (len_reg == '0) begin
                            st_next = ST_EMPTY;
                        end else begin
                            len_next = len_reg - 1'b1;
                        end
                    end
                    ACT_CLEAR: begin
                        len_next = '0;
                    end
                    ACT_RESIZE: begin
                        if (cnt_ext > DEPTH_C) begin
                            st_next = ST_FULL;
                        end else begin
                            ptr_next   = len_ext;
                            state_next = S_STEP;
                        end
                    end
                    default: begin
                        if (cnt_ext > DEPTH_C) begin
                            st_next = ST_FULL;
                        end else begin
                            ptr_next   = '0;
                            state_next = S_STEP;
                        end
                    end
                endcase
            end
            S_STEP: begin
                case (act_reg)
                    ACT_INSERT: begin
                        if (ptr_reg > idx_ext) begin
                            state_next = S_MOVE;
                        end else begin
                            we         = 1'b1;
                            len_next   = len_reg + 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    ACT_ERASE: begin
                        if (ptr_inc < len_ext) begin
                            state_next = S_MOVE;
                        end else begin
                            len_next   = len_reg - 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    default: begin
                        if (ptr_reg < cnt_ext) begin
                            we       = 1'b1;
                            ptr_next = ptr_inc;
                        end else begin
                            len_next   = LW'(cnt_ext);
                            state_next = S_DONE;
                        end
                    end
                endcase
            end
            S_MOVE: begin
                we         = 1'b1;
                wdata      = rdata;
                ptr_next   = (act_reg == ACT_INSERT) ? ptr_dec : ptr_inc;
                state_next = S_STEP;
            end
            S_RDCAP: begin
                rd_next    = rdata;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        rd_reg  <= rd_next;
        st_reg  <= st_next;
        if (s_tvalid && s_tready) begin
            act_reg <= s_tdata[2:0];
            idx_reg <= s_tdata[7:3];
            val_reg <= s_tdata[39:8];
            cnt_reg <= s_tdata[44:40];
        end
        if (out_load) begin
            m_tdata_reg <= {st_reg, (len_reg == '0), COUNT_W'(len_reg), rd_reg};
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(len_reg) <= DEPTH_C)
        else $error("list length exceeds the store depth");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while waiting to be taken");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready in the cycle after a transaction");

    a_len_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |=> $stable(len_reg))
        else $error("length changed while idle");
`endif

endmodule

`default_nettype wire
